// File: rtl/undo_redo_history_ring_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the undo/redo history ring
// Shared property forms; each expands to one labelled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef UNDO_REDO_HISTORY_RING_MACROS_SVH
`define UNDO_REDO_HISTORY_RING_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low
`define URHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low
`define URHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/urhr_pkg.sv
// ----------------------------------------------------------------------------
// urhr_pkg
// Types and fixed constants shared by the undo/redo history ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package urhr_pkg;

  localparam int HANDLE_W  = 8;
  localparam int DATA_W    = 64;
  localparam int LEN_W     = 4;
  localparam int SLOT_OUT_W = 6;

  typedef logic [1:0]            action_t;
  typedef logic [HANDLE_W-1:0]   handle_t;
  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [SLOT_OUT_W-1:0] slot_out_t;

  localparam action_t ACT_SUBMIT = 2'd0;
  localparam action_t ACT_UNDO   = 2'd1;
  localparam action_t ACT_REDO   = 2'd2;
  localparam action_t ACT_CLEAR  = 2'd3;

  // Cursor decision for one transaction, passed to the storage side
  typedef struct packed {
    logic acted;          // an entry is acted upon
    logic wr;             // submit: entry is written, result forwarded
    logic use_undo;       // issue the undo handle rather than the redo one
    logic undo_possible;  // cursor above zero afterwards
    logic redo_possible;  // cursor below live count afterwards
  } cur_ctl_t;

endpackage

`default_nettype wire

// File: rtl/urhr_if.sv
// ----------------------------------------------------------------------------
// urhr_if
// Valid/ready channels of the history ring: request and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface urhr_in_if;
  logic               valid;
  logic               ready;
  urhr_pkg::action_t  action;
  urhr_pkg::handle_t  redo_handle;
  urhr_pkg::handle_t  undo_handle;
  urhr_pkg::data_t    payload_data;
  urhr_pkg::len_t     payload_length;

  modport source (output valid, action, redo_handle, undo_handle, payload_data,
                  payload_length, input ready);
  modport sink   (input valid, action, redo_handle, undo_handle, payload_data,
                  payload_length, output ready);
endinterface

interface urhr_out_if;
  logic                valid;
  logic                ready;
  logic                call_valid;
  urhr_pkg::handle_t   call_handle;
  urhr_pkg::data_t     call_payload;
  urhr_pkg::slot_out_t entry_slot;
  logic                undo_possible;
  logic                redo_possible;

  modport source (output valid, call_valid, call_handle, call_payload, entry_slot,
                  undo_possible, redo_possible, input ready);
  modport sink   (input valid, call_valid, call_handle, call_payload, entry_slot,
                  undo_possible, redo_possible, output ready);
endinterface

`default_nettype wire

// File: rtl/urhr_cursor.sv
// ----------------------------------------------------------------------------
// urhr_cursor
// Ring pointers (oldest slot, live count, applied count) and slot selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urhr_cursor #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              fire,
  input  wire urhr_pkg::action_t                 action,
  output logic [$clog2(HISTORY_DEPTH)-1:0]       slot,
  output urhr_pkg::cur_ctl_t                     ctl
);
  import urhr_pkg::*;

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(HISTORY_DEPTH - 1);

  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  applied_r, applied_nxt;

  logic [SLOT_W-1:0] oldest_step;
  logic [CNT_W-1:0]  sub_base;

  // Slot of an offset from a base; the sum stays below twice the depth
  function automatic logic [SLOT_W-1:0] ring_pos(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + (SLOT_W + 1)'(off);
    if (sum >= (SLOT_W + 1)'(HISTORY_DEPTH)) begin
      sum = sum - (SLOT_W + 1)'(HISTORY_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign oldest_step = (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
  assign sub_base    = (applied_r == FULL_CNT) ? LAST_CNT : applied_r;

  // Decide the slot and the pointers after this transaction
  always_comb begin
    oldest_nxt  = oldest_r;
    live_nxt    = live_r;
    applied_nxt = applied_r;
    slot        = '0;
    ctl         = '0;
    case (action)
      ACT_SUBMIT: begin
        if (applied_r == FULL_CNT) begin
          oldest_nxt = oldest_step;
        end
        slot        = ring_pos(oldest_nxt, sub_base);
        live_nxt    = sub_base + 1'b1;
        applied_nxt = sub_base + 1'b1;
        ctl.acted   = 1'b1;
        ctl.wr      = 1'b1;
      end
      ACT_UNDO: begin
        if (applied_r != '0) begin
          applied_nxt  = applied_r - 1'b1;
          slot         = ring_pos(oldest_r, applied_nxt);
          ctl.acted    = 1'b1;
          ctl.use_undo = 1'b1;
        end
      end
      ACT_REDO: begin
        if (applied_r < live_r) begin
          slot        = ring_pos(oldest_r, applied_r);
          applied_nxt = applied_r + 1'b1;
          ctl.acted   = 1'b1;
        end
      end
      ACT_CLEAR: begin
        oldest_nxt  = '0;
        live_nxt    = '0;
        applied_nxt = '0;
      end
      default: begin
        oldest_nxt = oldest_r;
      end
    endcase
    ctl.undo_possible = (applied_nxt != '0);
    ctl.redo_possible = (applied_nxt < live_nxt);
  end

  // Advance the pointers on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r  <= '0;
      live_r    <= '0;
      applied_r <= '0;
    end else if (fire) begin
      oldest_r  <= oldest_nxt;
      live_r    <= live_nxt;
      applied_r <= applied_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/undo_redo_history_ring.sv
// ----------------------------------------------------------------------------
// undo_redo_history_ring
// Bounded undo/redo history: entries in a one-port synchronous RAM, cursor
// pointers in registers, one result per request.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries
//  in_ch    in   action, redo/undo handle, payload data and length
//  out_ch   out  callback valid/handle/payload, entry slot, undo/redo flags
//
//  Requests are taken one at a time: the RAM read of the entry is registered,
//  then the result register is loaded; a new request enters as the result
//  register is freed.
//  Reset (synchronous, active low) clears the pointers and the handshake
//  state; RAM contents are left as they are, and an unwritten entry never reaches the result.
//  A stalled result holds in the output register and blocks new requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module undo_redo_history_ring #(
  parameter int HISTORY_DEPTH = 64,
  parameter int PAYLOAD_BYTES = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  urhr_in_if.sink   in_ch,
  urhr_out_if.source out_ch
);
  import urhr_pkg::*;

  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int PAY_W   = 8 * PAYLOAD_BYTES;
  localparam int ENTRY_W = 2 * HANDLE_W + PAY_W;

  // Entry layout: redo handle, undo handle, payload
  localparam int REDO_HI = ENTRY_W - 1;
  localparam int UNDO_HI = ENTRY_W - 1 - HANDLE_W;

  logic              fire;
  logic [SLOT_W-1:0] cur_slot;
  cur_ctl_t          cur_ctl;

  logic [ENTRY_W-1:0] mem [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [ENTRY_W-1:0] wdata;
  logic [PAY_W-1:0]   masked;
  len_t               len_sat;

  logic               pend_r;
  cur_ctl_t           pend_ctl_r;
  logic [SLOT_W-1:0]  pend_slot_r;
  logic [ENTRY_W-1:0] pend_fwd_r;

  logic [ENTRY_W-1:0] entry;
  handle_t            sel_handle;

  logic      out_valid_r, out_valid_nxt;
  logic      call_valid_r;
  handle_t   call_handle_r;
  data_t     call_payload_r;
  slot_out_t entry_slot_r;
  logic      undo_possible_r;
  logic      redo_possible_r;

  assign in_ch.ready = !pend_r && (!out_valid_r || out_ch.ready);
  assign fire        = in_ch.valid && in_ch.ready;

  urhr_cursor #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .action (in_ch.action),
    .slot   (cur_slot),
    .ctl    (cur_ctl)
  );

  // Clear payload bytes past the saturated length
  always_comb begin
    len_sat = (in_ch.payload_length > LEN_W'(PAYLOAD_BYTES)) ?
              LEN_W'(PAYLOAD_BYTES) : in_ch.payload_length;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      masked[b*8 +: 8] = (LEN_W'(b) < len_sat) ? in_ch.payload_data[b*8 +: 8] : 8'h00;
    end
    wdata = {in_ch.redo_handle, in_ch.undo_handle, masked};
  end

  // Write the submitted entry
  always_ff @(posedge clk) begin
    if (fire && cur_ctl.wr) begin
      mem[cur_slot] <= wdata;
    end
  end

  // Read the addressed entry
  always_ff @(posedge clk) begin
    if (fire) begin
      rd_q <= mem[cur_slot];
    end
  end

  // Hold the decision while the read is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_ctl_r  <= cur_ctl;
      pend_slot_r <= cur_slot;
      pend_fwd_r  <= wdata;
    end
  end

  // Forward the new entry on submit, else take the RAM data
  assign entry      = pend_ctl_r.wr ? pend_fwd_r : rd_q;
  assign sel_handle = pend_ctl_r.use_undo ? entry[UNDO_HI -: HANDLE_W]
                                          : entry[REDO_HI -: HANDLE_W];

  // Result register: load when the read lands, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      call_valid_r    <= pend_ctl_r.acted && (sel_handle != '0);
      call_handle_r   <= pend_ctl_r.acted ? sel_handle : '0;
      call_payload_r  <= pend_ctl_r.acted ? DATA_W'(entry[PAY_W-1:0]) : '0;
      entry_slot_r    <= pend_ctl_r.acted ? SLOT_OUT_W'(pend_slot_r) : '0;
      undo_possible_r <= pend_ctl_r.undo_possible;
      redo_possible_r <= pend_ctl_r.redo_possible;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.call_valid    = call_valid_r;
  assign out_ch.call_handle   = call_handle_r;
  assign out_ch.call_payload  = call_payload_r;
  assign out_ch.entry_slot    = entry_slot_r;
  assign out_ch.undo_possible = undo_possible_r;
  assign out_ch.redo_possible = redo_possible_r;

  // Checks
`include "undo_redo_history_ring_macros.svh"

  `URHR_ASSERT_NEXT(a_one_in_flight, fire, !in_ch.ready, "request accepted while busy")
  `URHR_ASSERT_NOW(a_pend_out_free, pend_r, !out_valid_r, "read lands on a full result register")
  `URHR_ASSERT_NOW(a_call_handle, out_valid_r && call_valid_r, call_handle_r != '0,
                   "callback issued with null handle")

endmodule

`default_nettype wire

// File: bench/undo_redo_history_ring_test.sv
// ----------------------------------------------------------------------------
// undo_redo_history_ring_test
// Self-checking bench for the undo/redo history ring. A clocked driver feeds
// requests from a pending queue, a local model of the ring predicts each
// result at acceptance, and a clocked monitor compares every result
// transaction field by field. Directed cases come first, then random bursts
// of submits, undo/redo walks, branch rewrites and noise, run under several
// sender and receiver idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module undo_redo_history_ring_test;
  import urhr_pkg::*;

  localparam int unsigned HIST_DEPTH  = 64;
  localparam int unsigned PAY_BYTES   = 8;
  localparam int unsigned RANDOM_REQS = 1830;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef struct packed {
    action_t action;
    handle_t redo_handle;
    handle_t undo_handle;
    data_t   payload_data;
    len_t    payload_length;
  } history_req_t;

  typedef struct packed {
    logic      call_valid;
    handle_t   call_handle;
    data_t     call_payload;
    slot_out_t entry_slot;
    logic      undo_possible;
    logic      redo_possible;
  } call_result_t;

  logic clk;
  logic rst_n;

  urhr_in_if  req_ch ();
  urhr_out_if res_ch ();

  undo_redo_history_ring #(
    .HISTORY_DEPTH (HIST_DEPTH),
    .PAYLOAD_BYTES (PAY_BYTES)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Requests waiting to be driven and results waiting to arrive
  history_req_t pending_reqs[$];
  call_result_t expected_calls[$];

  // Local copy of the history ring
  handle_t     hist_redo [HIST_DEPTH];
  handle_t     hist_undo [HIST_DEPTH];
  data_t       hist_payload [HIST_DEPTH];
  int unsigned ring_base;
  int unsigned ring_live;
  int unsigned ring_cursor;

  // Idling profile of the current phase, percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned n_submit, n_undo, n_redo, n_clear, n_drops, n_empty_moves, n_results;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 30) $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  // Advance the local ring by one request and return its result
  function automatic call_result_t history_step(input history_req_t req);
    call_result_t res;
    int unsigned  len;
    int unsigned  slot;
    data_t        keep;
    res = '0;
    case (req.action)
      ACT_SUBMIT: begin
        n_submit++;
        len  = (req.payload_length > PAY_BYTES) ? PAY_BYTES : req.payload_length;
        keep = (len >= 8) ? '1 : ((data_t'(1) << (8 * len)) - data_t'(1));
        // drop the redo branch, then the oldest entry if the ring is full
        ring_live = ring_cursor;
        if (ring_live >= HIST_DEPTH) begin
          ring_base = (ring_base + 1) % HIST_DEPTH;
          ring_live = HIST_DEPTH - 1;
          n_drops++;
        end
        slot = (ring_base + ring_live) % HIST_DEPTH;
        ring_live++;
        ring_cursor = ring_live;
        hist_redo[slot]    = req.redo_handle;
        hist_undo[slot]    = req.undo_handle;
        hist_payload[slot] = req.payload_data & keep;
        res.call_valid   = (req.redo_handle != '0);
        res.call_handle  = req.redo_handle;
        res.call_payload = hist_payload[slot];
        res.entry_slot   = slot_out_t'(slot);
      end
      ACT_UNDO: begin
        n_undo++;
        if (ring_cursor == 0) begin
          n_empty_moves++;
        end else begin
          ring_cursor--;
          slot = (ring_base + ring_cursor) % HIST_DEPTH;
          res.call_valid   = (hist_undo[slot] != '0);
          res.call_handle  = hist_undo[slot];
          res.call_payload = hist_payload[slot];
          res.entry_slot   = slot_out_t'(slot);
        end
      end
      ACT_REDO: begin
        n_redo++;
        if (ring_cursor >= ring_live) begin
          n_empty_moves++;
        end else begin
          slot = (ring_base + ring_cursor) % HIST_DEPTH;
          ring_cursor++;
          res.call_valid   = (hist_redo[slot] != '0);
          res.call_handle  = hist_redo[slot];
          res.call_payload = hist_payload[slot];
          res.entry_slot   = slot_out_t'(slot);
        end
      end
      default: begin
        n_clear++;
        ring_base   = 0;
        ring_live   = 0;
        ring_cursor = 0;
      end
    endcase
    res.undo_possible = (ring_cursor > 0);
    res.redo_possible = (ring_cursor < ring_live);
    return res;
  endfunction

  function automatic void push_req(input action_t a, input handle_t rh, input handle_t uh,
                                   input data_t d, input len_t l);
    history_req_t req;
    req.action         = a;
    req.redo_handle    = rh;
    req.undo_handle    = uh;
    req.payload_data   = d;
    req.payload_length = l;
    pending_reqs.push_back(req);
  endfunction

  function automatic handle_t rand_handle();
    return ($urandom_range(0, 9) == 0) ? handle_t'(0) : handle_t'($urandom);
  endfunction

  // Queue a run of one action with random content
  task automatic queue_run(input action_t a, input int unsigned run, inout int unsigned left);
    len_t len;
    for (int unsigned i = 0; i < run && left > 0; i++) begin
      len = ($urandom_range(0, 4) == 0) ? len_t'($urandom_range(9, 15))
                                        : len_t'($urandom_range(0, 8));
      push_req(a, rand_handle(), rand_handle(), {$urandom, $urandom}, len);
      left--;
    end
  endtask

  // Random bursts: fill the ring, walk the cursor, rewrite branches, noise
  task automatic queue_random(input int unsigned count);
    int unsigned left;
    int unsigned kind;
    int unsigned pick;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        queue_run(ACT_SUBMIT, $urandom_range(60, 140), left);
      end else if (kind < 35) begin
        queue_run(ACT_UNDO, $urandom_range(1, 70), left);
        queue_run(ACT_REDO, $urandom_range(1, 70), left);
      end else if (kind < 50) begin
        queue_run(ACT_UNDO, $urandom_range(1, 10), left);
        queue_run(ACT_SUBMIT, $urandom_range(1, 5), left);
        queue_run(ACT_REDO, $urandom_range(1, 3), left);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 20)) begin
          pick = $urandom_range(0, 99);
          if (pick < 50)      queue_run(ACT_SUBMIT, 1, left);
          else if (pick < 75) queue_run(ACT_UNDO, 1, left);
          else if (pick < 99) queue_run(ACT_REDO, 1, left);
          else                queue_run(ACT_CLEAR, 1, left);
        end
      end else begin
        repeat ($urandom_range(1, 8)) queue_run(action_t'($urandom_range(0, 3)), 1, left);
      end
    end
  endtask

  // Directed cases: empty moves, zero handles, length extremes, branch drop
  task automatic queue_directed();
    push_req(ACT_UNDO,   8'h00, 8'h00, '0, 4'd0);
    push_req(ACT_REDO,   8'h00, 8'h00, '0, 4'd0);
    push_req(ACT_SUBMIT, 8'h00, 8'h00, '1, 4'd0);
    push_req(ACT_SUBMIT, 8'hFF, 8'hFF, '1, 4'd8);
    push_req(ACT_SUBMIT, 8'h5A, 8'hA5, 64'h0123_4567_89AB_CDEF, 4'd15);
    push_req(ACT_SUBMIT, 8'h01, 8'h80, 64'hFEDC_BA98_7654_3210, 4'd3);
    repeat (5) push_req(ACT_UNDO, 8'hFF, 8'hFF, '1, 4'd15);
    repeat (2) push_req(ACT_REDO, 8'h00, 8'h00, '1, 4'd15);
    push_req(ACT_SUBMIT, 8'h33, 8'hCC, 64'hAAAA_AAAA_AAAA_AAAA, 4'd9);
    push_req(ACT_REDO,   8'h00, 8'h00, '0, 4'd0);
    push_req(ACT_UNDO,   8'h00, 8'h00, '0, 4'd0);
    push_req(ACT_CLEAR,  8'hFF, 8'hFF, '1, 4'd15);
    push_req(ACT_UNDO,   8'h00, 8'h00, '0, 4'd0);
    push_req(ACT_REDO,   8'h00, 8'h00, '0, 4'd0);
    push_req(ACT_SUBMIT, 8'h80, 8'h01, 64'h5555_5555_5555_5555, 4'd1);
    push_req(ACT_SUBMIT, 8'h7F, 8'h00, 64'hAAAA_AAAA_AAAA_AAAA, 4'd7);
    push_req(ACT_UNDO,   8'h00, 8'h00, '0, 4'd0);
    push_req(ACT_REDO,   8'h00, 8'h00, '0, 4'd0);
    push_req(ACT_CLEAR,  8'h00, 8'h00, '0, 4'd0);
  endtask

  // Driver: predict on acceptance, hold an offered request until taken
  always @(posedge clk) begin
    history_req_t req;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        req.action         = req_ch.action;
        req.redo_handle    = req_ch.redo_handle;
        req.undo_handle    = req_ch.undo_handle;
        req.payload_data   = req_ch.payload_data;
        req.payload_length = req_ch.payload_length;
        expected_calls.push_back(history_step(req));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          req_ch.action         <= req.action;
          req_ch.redo_handle    <= req.redo_handle;
          req_ch.undo_handle    <= req.undo_handle;
          req_ch.payload_data   <= req.payload_data;
          req_ch.payload_length <= req.payload_length;
          req_ch.valid          <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin
    call_result_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_results++;
        if (expected_calls.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = expected_calls.pop_front();
          if (res_ch.call_valid !== want.call_valid)
            flag_mismatch($sformatf("call_valid %b, want %b", res_ch.call_valid,
                                    want.call_valid));
          if (res_ch.call_handle !== want.call_handle)
            flag_mismatch($sformatf("call_handle %h, want %h", res_ch.call_handle,
                                    want.call_handle));
          if (res_ch.call_payload !== want.call_payload)
            flag_mismatch($sformatf("call_payload %h, want %h", res_ch.call_payload,
                                    want.call_payload));
          if (res_ch.entry_slot !== want.entry_slot)
            flag_mismatch($sformatf("entry_slot %0d, want %0d", res_ch.entry_slot,
                                    want.entry_slot));
          if (res_ch.undo_possible !== want.undo_possible)
            flag_mismatch($sformatf("undo_possible %b, want %b", res_ch.undo_possible,
                                    want.undo_possible));
          if (res_ch.redo_possible !== want.redo_possible)
            flag_mismatch($sformatf("redo_possible %b, want %b", res_ch.redo_possible,
                                    want.redo_possible));
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("undo_redo_history_ring: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sequence: reset, directed cases, then random phases with varied idling
  initial begin
    int unsigned send_prof [PHASES];
    int unsigned recv_prof [PHASES];
    send_prof = '{0, 69, 0, 19, 0};
    recv_prof = '{0, 0, 69, 19, 0};

    rst_n                 = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.action         = ACT_SUBMIT;
    req_ch.redo_handle    = '0;
    req_ch.undo_handle    = '0;
    req_ch.payload_data   = '0;
    req_ch.payload_length = '0;
    res_ch.ready          = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    mismatches            = 0;
    quiet_cycles          = 0;
    ring_base             = 0;
    ring_live             = 0;
    ring_cursor           = 0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_redo[i]    = '0;
      hist_undo[i]    = '0;
      hist_payload[i] = '0;
    end
    {n_submit, n_undo, n_redo, n_clear, n_drops, n_empty_moves, n_results} = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_directed();
    for (int unsigned p = 0; p < PHASES; p++) begin
      send_idle_pct  = send_prof[p];
      recv_stall_pct = recv_prof[p];
      queue_random(RANDOM_REQS / PHASES);
      // drain before switching the idling profile
      while (pending_reqs.size() != 0 || req_ch.valid || expected_calls.size() != 0)
        @(negedge clk);
    end

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d results: %0d submits, %0d undos, %0d redos, %0d clears",
             n_results, n_submit, n_undo, n_redo, n_clear);
    $display("ring overflowed %0d times, %0d undo/redo requests found nothing to move",
             n_drops, n_empty_moves);
    if (mismatches == 0) begin
      $display("undo_redo_history_ring: match");
    end else begin
      $display("undo_redo_history_ring: mismatch");
    end
    $finish;
  end

endmodule
